>>> src/ptw_pkg.sv
// Shared types, constants and helpers for the page table walk and map engine.
package ptw_pkg;

  // Store geometry: byte addresses, 64-bit words, 4 KB tables of 512 entries.
  localparam int MEM_ADDR_BITS = 16;
  localparam int WORD_BITS     = MEM_ADDR_BITS - 3;
  localparam int BASE_BITS     = MEM_ADDR_BITS - 12;
  localparam int VPN_BITS      = 36;
  localparam int PG_BITS       = VPN_BITS + 1;

  localparam logic [15:0] ALLOC_START = 16'h8000;
  localparam logic [15:0] PAGE_BYTES  = 16'd4096;
  localparam logic [8:0]  TABLE_LAST  = 9'd511;
  localparam logic [11:0] FLAG_LINK   = 12'h007;
  localparam int          BIT_PRESENT = 0;
  localparam int          BIT_HUGE    = 7;
  localparam int          BIT_NX      = 63;
  localparam logic [48:0] PAGE_ROUND  = 49'h0_0000_0000_0FFF;

  // Action codes as they arrive on the input.
  localparam logic [2:0] CODE_READ   = 3'd0;
  localparam logic [2:0] CODE_WRITE  = 3'd1;
  localparam logic [2:0] CODE_LOOKUP = 3'd2;
  localparam logic [2:0] CODE_MAP    = 3'd3;
  localparam logic [2:0] CODE_CLEAR  = 3'd4;
  localparam logic [2:0] CODE_CLONE  = 3'd5;

  // Configuration register indexes.
  localparam logic REG_CURRENT_ROOT = 1'b0;

  // Decoded operation.
  typedef enum logic [2:0] {
    ACT_READ, ACT_WRITE, ACT_LOOKUP, ACT_MAP, ACT_CLEAR, ACT_CLONE, ACT_NOP
  } act_t;

  // One queued request after decode.
  typedef struct packed {
    act_t         act;
    logic [47:0]  virtual_address;
    logic [15:0]  physical_address;
    logic [15:0]  root_address;
    logic [63:0]  write_data;
    logic [23:0]  range_bytes;
  } req_t;

  // Sequencer states of the back end.
  typedef enum logic [3:0] {
    S_IDLE, S_RD_ISSUE, S_RD_DATA, S_WR, S_WALK_ISSUE, S_WALK_DATA, S_FIX_WR,
    S_CLR_NEXT, S_MAP_ISSUE, S_MAP_DATA, S_ZERO, S_LINK, S_CLONE_RD,
    S_CLONE_WR, S_DONE
  } state_t;

  // Table index of a virtual page number at a given level (3 is the top).
  function automatic logic [8:0] vpn_idx(input logic [VPN_BITS-1:0] vpn,
                                         input logic [1:0] lvl);
    logic [8:0] r;
    unique case (lvl)
      2'd3: r = vpn[35:27];
      2'd2: r = vpn[26:18];
      2'd1: r = vpn[17:9];
      default: r = vpn[8:0];
    endcase
    return r;
  endfunction

endpackage

>>> src/page_table_walk_and_map_engine_core.sv
// The back end carries out one request at a time and takes the next from the queue only
// once the result of the last has gone into the result register; a two-entry request
// queue and the result register decouple both sides.
// Reset (rst, synchronous) empties the request queue and the result register and sets
// the allocator to its start page; the table store is not cleared and reads undefined
// until written.
module page_table_walk_and_map_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action,
  input  logic [47:0] virtual_address,
  input  logic [15:0] physical_address,
  input  logic [15:0] root_address,
  input  logic [63:0] write_data,
  input  logic [23:0] range_bytes,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] read_data,
  output logic [15:0] entry_address,
  output logic        found,
  output logic [15:0] new_root,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptw_pkg::*;

  logic        req_valid;
  req_t        req;
  logic        req_pop;
  logic [15:0] current_root;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      current_root <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CURRENT_ROOT) begin
      current_root <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == REG_CURRENT_ROOT) ? {16'd0, current_root} : 32'd0;

  // Request queue and decode.
  ptw_front u_front (
    .clk, .rst, .push, .full, .action, .virtual_address, .physical_address,
    .root_address, .write_data, .range_bytes, .req_valid, .req, .req_pop
  );

  // Sequencer with the table store.
  ptw_back u_back (
    .clk, .rst, .req_valid, .req, .req_pop, .current_root, .empty, .pop,
    .read_data, .entry_address, .found, .new_root
  );

endmodule

>>> src/ptw_front.sv
// Front end: decodes incoming requests and holds them in a two-entry queue.
module ptw_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [2:0]            action,
  input  logic [47:0]           virtual_address,
  input  logic [15:0]           physical_address,
  input  logic [15:0]           root_address,
  input  logic [63:0]           write_data,
  input  logic [23:0]           range_bytes,
  output logic                  req_valid,
  output ptw_pkg::req_t         req,
  input  logic                  req_pop
);
  import ptw_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  act_t       act_dec;

  // Classify the action code; unused codes become a no-op.
  always_comb begin
    unique case (action)
      CODE_READ:   act_dec = ACT_READ;
      CODE_WRITE:  act_dec = ACT_WRITE;
      CODE_LOOKUP: act_dec = ACT_LOOKUP;
      CODE_MAP:    act_dec = ACT_MAP;
      CODE_CLEAR:  act_dec = ACT_CLEAR;
      CODE_CLONE:  act_dec = ACT_CLONE;
      default:     act_dec = ACT_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_pop && req_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{act: act_dec, virtual_address: virtual_address,
                         physical_address: physical_address,
                         root_address: root_address, write_data: write_data,
                         range_bytes: range_bytes};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> req_valid) else $error("pop from empty request queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("request queue overfilled");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 2'd1)
    else $error("queue count missed a push");
`endif

endmodule

>>> src/ptw_back.sv
// Back end: table store, walk/map/clear/clone sequencer and result register.
module ptw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  ptw_pkg::req_t         req,
  output logic                  req_pop,
  input  logic [15:0]           current_root,
  output logic                  empty,
  input  logic                  pop,
  output logic [63:0]           read_data,
  output logic [15:0]           entry_address,
  output logic                  found,
  output logic [15:0]           new_root
);
  import ptw_pkg::*;

  // Table store, one write and one registered read per cycle.
  logic [63:0] mem [2**WORD_BITS];
  logic [63:0] rdata;
  logic                  mem_we;
  logic [WORD_BITS-1:0]  mem_waddr;
  logic [63:0]           mem_wdata;
  logic [WORD_BITS-1:0]  mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  state_t state;
  state_t state_next;

  // Work registers.
  act_t                  op;
  logic [VPN_BITS-1:0]   vpn;
  logic [15:0]           pa;
  logic [63:0]           wdata;
  logic [1:0]            level;
  logic [BASE_BITS-1:0]  base;
  logic [WORD_BITS-1:0]  where;
  logic [63:0]           entry;
  logic [PG_BITS-1:0]    pg;
  logic [PG_BITS-1:0]    pg_end;
  logic [8:0]            cnt;
  logic [15:0]           page;
  logic [15:0]           alloc_page;
  logic [63:0]           res_data;
  logic [15:0]           res_where;
  logic                  res_found;
  logic [15:0]           res_new_root;
  logic                  out_valid;

  // Derived values.
  logic [48:0]           range_sum;
  logic [PG_BITS-1:0]    start_pg;
  logic [PG_BITS-1:0]    end_pg;
  logic [PG_BITS-1:0]    pg_plus;
  logic [WORD_BITS-1:0]  entry_word;
  logic                  walk_stop;
  logic                  walk_found;
  logic                  out_load;

  assign range_sum  = {1'b0, req.virtual_address} + {25'd0, req.range_bytes} + PAGE_ROUND;
  assign start_pg   = {1'b0, req.virtual_address[47:12]};
  assign end_pg     = range_sum[48:12];
  assign pg_plus    = pg + {{(PG_BITS-1){1'b0}}, 1'b1};
  assign entry_word = {base, vpn_idx(vpn, level)};
  assign walk_stop  = (level == 2'd0) || !rdata[BIT_PRESENT] ||
                      ((level != 2'd3) && rdata[BIT_HUGE]);
  assign walk_found = (level == 2'd0) ||
                      (rdata[BIT_PRESENT] && (level != 2'd3) && rdata[BIT_HUGE]);
  assign out_load   = (state == S_DONE) && (!out_valid || pop);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.act)
            ACT_READ:   state_next = S_RD_ISSUE;
            ACT_WRITE:  state_next = S_WR;
            ACT_LOOKUP: state_next = S_WALK_ISSUE;
            ACT_MAP:    state_next = S_MAP_ISSUE;
            ACT_CLEAR:  state_next = (start_pg < end_pg) ? S_WALK_ISSUE : S_DONE;
            ACT_CLONE:  state_next = S_ZERO;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_RD_ISSUE:   state_next = S_RD_DATA;
      S_RD_DATA:    state_next = S_DONE;
      S_WR:         state_next = S_DONE;
      S_WALK_ISSUE: state_next = S_WALK_DATA;
      S_WALK_DATA: begin
        if (!walk_stop) state_next = S_WALK_ISSUE;
        else if (op == ACT_CLEAR) state_next = walk_found ? S_FIX_WR : S_CLR_NEXT;
        else state_next = S_DONE;
      end
      S_FIX_WR:     state_next = S_CLR_NEXT;
      S_CLR_NEXT:   state_next = (pg_plus < pg_end) ? S_WALK_ISSUE : S_DONE;
      S_MAP_ISSUE:  state_next = (level == 2'd0) ? S_DONE : S_MAP_DATA;
      S_MAP_DATA:   state_next = rdata[BIT_PRESENT] ? S_MAP_ISSUE : S_ZERO;
      S_ZERO: begin
        if (cnt == TABLE_LAST) state_next = (op == ACT_CLONE) ? S_CLONE_RD : S_LINK;
      end
      S_LINK:       state_next = S_MAP_ISSUE;
      S_CLONE_RD:   state_next = S_CLONE_WR;
      S_CLONE_WR:   state_next = (cnt == TABLE_LAST) ? S_DONE : S_CLONE_RD;
      S_DONE:       state_next = out_load ? S_IDLE : S_DONE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Store port controls and request pop.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    req_pop   = 1'b0;
    unique case (state)
      S_IDLE:       req_pop = req_valid;
      S_RD_ISSUE:   mem_raddr = pa[15:3];
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pa[15:3];
        mem_wdata = wdata;
      end
      S_WALK_ISSUE: mem_raddr = entry_word;
      S_FIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = where;
        mem_wdata = {1'b0, entry[62:0]};
      end
      S_MAP_ISSUE: begin
        mem_raddr = entry_word;
        if (level == 2'd0) begin
          mem_we    = 1'b1;
          mem_waddr = entry_word;
          mem_wdata = {48'd0, pa[15:12], FLAG_LINK};
        end
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = page[15:3] + {{(WORD_BITS-9){1'b0}}, cnt};
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = where;
        mem_wdata = {48'd0, page | {4'd0, FLAG_LINK}};
      end
      S_CLONE_RD:   mem_raddr = {current_root[15:12], cnt};
      S_CLONE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = page[15:3] + {{(WORD_BITS-9){1'b0}}, cnt};
        mem_wdata = rdata;
      end
      default: ;
    endcase
  end

  // State register, allocator and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      alloc_page <= ALLOC_START;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_IDLE && req_valid && req.act == ACT_CLONE) ||
          (state == S_MAP_DATA && !rdata[BIT_PRESENT])) begin
        alloc_page <= alloc_page + PAGE_BYTES;
      end
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // Work datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op           <= req.act;
        pa           <= req.physical_address;
        wdata        <= req.write_data;
        vpn          <= req.virtual_address[47:12];
        level        <= 2'd3;
        base         <= (req.act == ACT_CLEAR) ? current_root[15:12]
                                               : req.root_address[15:12];
        pg           <= start_pg;
        pg_end       <= end_pg;
        page         <= alloc_page;
        cnt          <= '0;
        res_data     <= '0;
        res_where    <= '0;
        res_found    <= 1'b0;
        res_new_root <= '0;
      end
      S_RD_DATA:    res_data <= rdata;
      S_WALK_ISSUE: where <= entry_word;
      S_WALK_DATA: begin
        if (!walk_stop) begin
          base  <= rdata[15:12];
          level <= level - 2'd1;
        end else if (walk_found) begin
          entry <= rdata;
          if (op == ACT_LOOKUP) begin
            res_data  <= rdata;
            res_where <= {where, 3'b000};
            res_found <= 1'b1;
          end
        end
      end
      S_CLR_NEXT: begin
        pg    <= pg_plus;
        vpn   <= pg_plus[VPN_BITS-1:0];
        level <= 2'd3;
        base  <= current_root[15:12];
      end
      S_MAP_ISSUE:  where <= entry_word;
      S_MAP_DATA: begin
        if (rdata[BIT_PRESENT]) begin
          base  <= rdata[15:12];
          level <= level - 2'd1;
        end else begin
          page <= alloc_page;
          cnt  <= '0;
        end
      end
      S_ZERO:       cnt <= cnt + 9'd1;
      S_LINK: begin
        base  <= page[15:12];
        level <= level - 2'd1;
      end
      S_CLONE_WR: begin
        cnt <= cnt + 9'd1;
        if (cnt == TABLE_LAST) res_new_root <= page;
      end
      default: ;
    endcase
  end

  // Result register toward the consumer.
  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data     <= res_data;
      entry_address <= res_where;
      found         <= res_found;
      new_root      <= res_new_root;
    end
  end

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> (state == S_IDLE) && req_valid)
    else $error("request taken outside idle");
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_ZERO) && (cnt != TABLE_LAST) |=> (state == S_ZERO) &&
    (cnt == $past(cnt) + 9'd1)) else $error("zeroing sweep skipped a word");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(read_data))
    else $error("waiting result lost");
`endif

endmodule

>>> tb/tb_page_table_walk_and_map_engine_core.sv
// Self-checking testbench for the page table walk and map engine core.
module tb_page_table_walk_and_map_engine_core;
  import ptw_pkg::*;

  // Action codes that the block must ignore.
  localparam logic [2:0] CODE_SPARE_LO = 3'd6;
  localparam logic [2:0] CODE_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned HOLD_CYCLES  = 400;

  // One request as it is presented on the input side.
  typedef struct {
    logic [2:0]  action;
    logic [47:0] va;
    logic [15:0] pa;
    logic [15:0] root;
    logic [63:0] wdata;
    logic [23:0] len;
  } ptw_op_t;

  // One result as it leaves the block.
  typedef struct {
    logic [63:0] read_data;
    logic [15:0] entry_address;
    logic        found;
    logic [15:0] new_root;
  } ptw_res_t;

  // Scoreboard: keeps its own copy of the table store and predicts each result.
  class ptw_scoreboard;
    logic [63:0] words [8192];
    logic [15:0] alloc_ptr;
    logic [15:0] root_reg;
    ptw_res_t    pending [$];
    ptw_res_t    last_pred;
    int          errors;
    int          checked;
    int          per_action [8];

    function new();
      alloc_ptr = ALLOC_START;
      root_reg  = 16'h0000;
      errors    = 0;
      checked   = 0;
      foreach (words[i]) words[i] = 64'h0;
      foreach (per_action[i]) per_action[i] = 0;
    endfunction

    function logic [63:0] rd(logic [15:0] a);
      return words[a[15:3]];
    endfunction

    // Byte address of the entry at one table level.
    function logic [15:0] slot(logic [15:0] base, logic [47:0] va, int shift);
      logic [8:0] idx;
      idx = 9'((va >> shift) & 48'h1FF);
      return {base[15:12], 12'h000} + {4'h0, idx, 3'b000};
    endfunction

    function logic walk(logic [15:0] root, logic [47:0] va, output logic [15:0] where);
      logic [63:0] e;
      logic [15:0] a;
      where = 16'h0;
      a = slot(root, va, 39);
      e = rd(a);
      if (!e[BIT_PRESENT]) return 1'b0;
      a = slot(e[15:0], va, 30);
      e = rd(a);
      if (!e[BIT_PRESENT]) return 1'b0;
      if (e[BIT_HUGE]) begin
        where = a;
        return 1'b1;
      end
      a = slot(e[15:0], va, 21);
      e = rd(a);
      if (!e[BIT_PRESENT]) return 1'b0;
      if (e[BIT_HUGE]) begin
        where = a;
        return 1'b1;
      end
      where = slot(e[15:0], va, 12);
      return 1'b1;
    endfunction

    // Bump allocation of one zeroed table.
    function logic [15:0] grab_table();
      logic [15:0] p;
      logic [12:0] w;
      p = alloc_ptr;
      alloc_ptr = alloc_ptr + PAGE_BYTES;
      w = p[15:3];
      for (int i = 0; i < 512; i++) words[13'(w + i)] = 64'h0;
      return p;
    endfunction

    function logic [63:0] link_level(logic [15:0] a);
      logic [63:0] e;
      e = rd(a);
      if (!e[BIT_PRESENT]) begin
        e = {48'h0, grab_table()} | {52'h0, FLAG_LINK};
        words[a[15:3]] = e;
      end
      return e;
    endfunction

    function ptw_res_t compute(ptw_op_t o);
      ptw_res_t    r;
      logic [15:0] where;
      logic [63:0] e;
      logic [48:0] pg;
      logic [48:0] stop;
      logic [12:0] src;
      logic [12:0] dst;
      r = '{64'h0, 16'h0, 1'b0, 16'h0};
      case (o.action)
        CODE_READ: r.read_data = rd(o.pa);
        CODE_WRITE: words[o.pa[15:3]] = o.wdata;
        CODE_LOOKUP: begin
          if (walk(o.root, o.va, where)) begin
            r.read_data = rd(where);
            r.entry_address = where;
            r.found = 1'b1;
          end
        end
        CODE_MAP: begin
          e = link_level(slot(o.root, o.va, 39));
          e = link_level(slot(e[15:0], o.va, 30));
          e = link_level(slot(e[15:0], o.va, 21));
          where = slot(e[15:0], o.va, 12);
          words[where[15:3]] = {48'h0, o.pa[15:12], FLAG_LINK};
        end
        CODE_CLEAR: begin
          pg   = {1'b0, o.va} & ~PAGE_ROUND;
          stop = ({1'b0, o.va} + {25'h0, o.len} + PAGE_ROUND) & ~PAGE_ROUND;
          while (pg < stop) begin
            if (walk(root_reg, pg[47:0], where)) words[where[15:3]][BIT_NX] = 1'b0;
            pg += 49'd4096;
          end
        end
        CODE_CLONE: begin
          r.new_root = grab_table();
          src = {root_reg[15:12], 9'h0};
          dst = r.new_root[15:3];
          for (int i = 0; i < 512; i++) words[13'(dst + i)] = words[13'(src + i)];
        end
        default: ;
      endcase
      return r;
    endfunction

    // Called for every request the block accepts.
    function void note_request(ptw_op_t o);
      last_pred = compute(o);
      per_action[o.action]++;
      pending.push_back(last_pred);
    endfunction

    // Called for every result the block hands over.
    function void check_result(ptw_res_t a);
      ptw_res_t x;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, read_data %h", $time, a.read_data);
        return;
      end
      x = pending.pop_front();
      if (a.read_data !== x.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, x.read_data, a.read_data);
      end
      if (a.entry_address !== x.entry_address) begin
        errors++;
        $display("%0t: entry_address expected %h actual %h", $time,
                 x.entry_address, a.entry_address);
      end
      if (a.found !== x.found) begin
        errors++;
        $display("%0t: found expected %b actual %b", $time, x.found, a.found);
      end
      if (a.new_root !== x.new_root) begin
        errors++;
        $display("%0t: new_root expected %h actual %h", $time, x.new_root, a.new_root);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  action = CODE_READ;
  logic [47:0] virtual_address = '0;
  logic [15:0] physical_address = '0;
  logic [15:0] root_address = '0;
  logic [63:0] write_data = '0;
  logic [23:0] range_bytes = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] read_data;
  logic [15:0] entry_address;
  logic        found;
  logic [15:0] new_root;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ptw_scoreboard sb = new();
  logic [47:0]   va_pool [$];
  logic [15:0]   root_pool [$];
  int unsigned   cycle_count = 0;
  bit            hold_req = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   stall_left = 0;
  int            sent = 0;

  page_table_walk_and_map_engine_core i_dut (.*);

  always #5 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each popped result and stall at random, or for a long hold.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result('{read_data, entry_address, found, new_root});
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (cycle_count % 512 >= 128) begin
        if ($urandom_range(99) < 3) stall_left = $urandom_range(60, 20);
        else if ($urandom_range(99) < 15) stall_left = $urandom_range(3, 1);
      end
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send(ptw_op_t o);
    push             <= 1'b1;
    action           <= o.action;
    virtual_address  <= o.va;
    physical_address <= o.pa;
    root_address     <= o.root;
    write_data       <= o.wdata;
    range_bytes      <= o.len;
    do @(posedge clk); while (full);
    sb.note_request(o);
    sent++;
    if (o.action == CODE_CLONE) root_pool.push_back(sb.last_pred.new_root);
    if (o.action == CODE_MAP) va_pool.push_back(o.va);
  endtask

  // Gap after a request; long gaps are rare and quiet stretches have none.
  task automatic idle_gap();
    int unsigned n;
    n = 0;
    if (sent % 80 >= 20) begin
      if ($urandom_range(99) < 4) n = $urandom_range(50, 15);
      else if ($urandom_range(99) < 30) n = $urandom_range(3, 1);
    end
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(logic [2:0] act, logic [47:0] va, logic [15:0] pa,
                       logic [15:0] root, logic [63:0] wd, logic [23:0] len);
    send('{act, va, pa, root, wd, len});
    idle_gap();
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write over the configuration port; the block must be idle.
  task automatic set_current_root(logic [15:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CURRENT_ROOT, 2'b00};
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.root_reg = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [47:0] pick_va();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    if (va_pool.size() > 0 && $urandom_range(99) < 65) begin
      v = va_pool[$urandom_range(va_pool.size() - 1)];
      case ($urandom_range(2))
        0: v[11:0] = 12'($urandom);
        1: v[20:0] = 21'($urandom);
        default: ;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_root();
    if (root_pool.size() > 0 && $urandom_range(99) < 80)
      return root_pool[$urandom_range(root_pool.size() - 1)];
    return 16'($urandom);
  endfunction

  // One random request, weighted toward table walks with meaningful content.
  task automatic random_request();
    int unsigned sel;
    logic [63:0] wd;
    logic [23:0] len;
    sel = $urandom_range(99);
    wd  = {$urandom, $urandom};
    if ($urandom_range(1)) wd = {wd[63], 47'h0, wd[15:12], wd[11:0] | 12'h001};
    len = ($urandom_range(199) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
    if (sel < 14) issue(CODE_READ, pick_va(), 16'($urandom), pick_root(), wd, len);
    else if (sel < 28) issue(CODE_WRITE, pick_va(), 16'($urandom), pick_root(), wd, len);
    else if (sel < 62) issue(CODE_LOOKUP, pick_va(), 16'($urandom), pick_root(), wd, len);
    else if (sel < 74) issue(CODE_MAP, pick_va(), 16'($urandom), pick_root(), wd, len);
    else if (sel < 90) issue(CODE_CLEAR, pick_va(), 16'($urandom), pick_root(), wd, len);
    else if (sel < 93) issue(CODE_CLONE, pick_va(), 16'($urandom), pick_root(), wd, len);
    else if (sel < 95) issue(sel[0] ? CODE_SPARE_LO : CODE_SPARE_HI, pick_va(),
                             16'($urandom), pick_root(), wd, len);
    else issue(CODE_LOOKUP, pick_va(), 16'($urandom), 16'h0000, wd, len);
  endtask

  // Main stimulus.
  initial begin
    root_pool.push_back(16'h0000);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_current_root(16'h0000);

    // Make every store word defined: each map allocates and zeroes three tables.
    for (int k = 0; k < 6; k++) begin
      issue(CODE_WRITE, '0, 16'(k * 8), '0, 64'h0, '0);
      issue(CODE_MAP, {9'(k), 39'h12_3456_7000}, 16'(16'h1000 * k), 16'h0000, '0, '0);
    end

    // Directed: field extremes, both huge page sizes, not found, every action.
    issue(CODE_WRITE, '1, 16'hFFFF, '1, '1, '1);
    issue(CODE_READ, '0, 16'hFFFF, '0, '0, '0);
    issue(CODE_READ, '0, 16'h0007, '0, '0, '0);
    issue(CODE_LOOKUP, {9'd2, 39'h12_3456_7ABC}, '0, 16'h0FFF, '0, '0);
    issue(CODE_LOOKUP, {9'd300, 39'h0}, '0, 16'h0000, '0, '0);
    issue(CODE_WRITE, '0, 16'h1000, '0, 64'h0000_0000_0000_2001, '0);
    issue(CODE_WRITE, '0, 16'h2000, '0, 64'h8000_00AB_C000_0083, '0);
    issue(CODE_LOOKUP, 48'h0000_1234_5678, '0, 16'h1000, '0, '0);
    issue(CODE_WRITE, '0, 16'h2008, '0, 64'h0000_0000_0000_3001, '0);
    issue(CODE_WRITE, '0, 16'h3000, '0, 64'h8000_0000_0020_0083, '0);
    issue(CODE_LOOKUP, 48'h0000_4000_0123, '0, 16'h1000, '0, '0);
    issue(CODE_MAP, '1, 16'hFFFF, 16'hFFFF, '0, '0);
    issue(CODE_LOOKUP, '1, '0, 16'hFFFF, '0, '0);
    issue(CODE_SPARE_LO, '1, '1, '1, '1, '1);
    issue(CODE_SPARE_HI, '0, '0, '0, '0, '0);
    set_current_root(16'h1000);
    issue(CODE_CLEAR, 48'h0000_0000_0FFF, '0, '0, '0, 24'h40_0000);
    issue(CODE_CLONE, '0, '0, '0, '0, '0);
    issue(CODE_CLEAR, 48'hFFFF_FFFF_F000, '0, '0, '0, 24'hFF_FFFF);

    // Random phases under several register settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_current_root(16'hFFFF);
        1: set_current_root(16'h0000);
        2: set_current_root(16'($urandom));
        default: set_current_root(root_pool[$urandom_range(root_pool.size() - 1)]);
      endcase
      for (int n = 0; n < 155; n++) begin
        // Hold the result side off long enough to back the block up.
        if (ph == 1 && n == 20) hold_req = 1'b1;
        // Let everything drain once with the input quiet.
        if (ph == 2 && n == 70) begin
          push <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        random_request();
      end
    end

    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests, checked %0d results over %0d cycles.",
             sent, sb.checked, cycle_count);
    $display("Per action: read %0d write %0d lookup %0d map %0d clear %0d clone %0d spare %0d",
             sb.per_action[CODE_READ], sb.per_action[CODE_WRITE], sb.per_action[CODE_LOOKUP],
             sb.per_action[CODE_MAP], sb.per_action[CODE_CLEAR], sb.per_action[CODE_CLONE],
             sb.per_action[CODE_SPARE_LO] + sb.per_action[CODE_SPARE_HI]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> page_table_walk_and_map_engine_core.f
src/ptw_pkg.sv
src/ptw_front.sv
src/ptw_back.sv
src/page_table_walk_and_map_engine_core.sv
tb/tb_page_table_walk_and_map_engine_core.sv
